// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the top-k keeper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, switched off while reset is asserted
`define HTK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define HTK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/htk_pkg.sv =====
// ----------------------------------------------------------------------------
// htk_pkg
// Types, constants and helpers of the streaming top-k min-heap keeper.
// ----------------------------------------------------------------------------
package htk_pkg;

  localparam int CAPACITY   = 32;
  localparam int LEVEL_BITS = 16;
  localparam int TAG_BITS   = 32;
  localparam int CNT_BITS   = 32;
  localparam int K_BITS     = 6;
  localparam int IDX_BITS   = 5;
  localparam int RANK_BITS  = 5;
  localparam int ADDR_BITS  = 3;

  localparam logic [K_BITS-1:0] KEEP_RESET = K_BITS'(CAPACITY);

  // request and result codes
  localparam logic REQ_ENTRY    = 1'b0;
  localparam logic REQ_FINISH   = 1'b1;
  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_RANKED  = 1'b1;

  // register index (paddr word index)
  localparam logic REG_KEEP_COUNT = 1'b0;

  typedef struct packed {
    logic                  req_type;
    logic [LEVEL_BITS-1:0] level;
    logic [TAG_BITS-1:0]   tag;
  } item_t;

  typedef struct packed {
    logic              busy;
    logic [K_BITS-1:0] held;
  } status_t;

  // k with the out-of-range codes folded in
  function automatic logic [K_BITS-1:0] eff_k(input logic [K_BITS-1:0] raw);
    logic [K_BITS-1:0] k;
    k = raw;
    if (k == '0) k = K_BITS'(1);
    if (k > K_BITS'(CAPACITY)) k = K_BITS'(CAPACITY);
    return k;
  endfunction

  // heap order: level only, or level then tag
  function automatic logic key_less(input logic [LEVEL_BITS-1:0] al,
                                    input logic [TAG_BITS-1:0]   at,
                                    input logic [LEVEL_BITS-1:0] bl,
                                    input logic [TAG_BITS-1:0]   bt,
                                    input logic                  comp);
    logic r;
    r = (al < bl) || (comp && (al == bl) && (at < bt));
    return r;
  endfunction

endpackage

// ===== rtl/htk_front.sv =====
// ----------------------------------------------------------------------------
// htk_front
// Input side: takes items and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module htk_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [htk_pkg::LEVEL_BITS-1:0]  level_i,
  input  logic [htk_pkg::TAG_BITS-1:0]    entry_tag_i,
  output logic                            item_valid_o,
  output htk_pkg::item_t                  item_o,
  input  logic                            item_pop_i
);

  htk_pkg::item_t q_mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = q_mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= '{req_type: req_type_i, level: level_i, tag: entry_tag_i};
    end
  end

endmodule

// ===== rtl/htk_back.sv =====
// ----------------------------------------------------------------------------
// htk_back
// Engine: heap store, sift-down unit, drain sequencer and result register.
// ----------------------------------------------------------------------------
module htk_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [htk_pkg::K_BITS-1:0]      keep_k_i,
  input  logic                            k_wr_i,
  input  logic                            item_valid_i,
  input  htk_pkg::item_t                  item_i,
  output logic                            item_pop_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            result_kind_o,
  output logic [htk_pkg::CNT_BITS-1:0]    seen_count_o,
  output logic [htk_pkg::LEVEL_BITS-1:0]  out_level_o,
  output logic [htk_pkg::TAG_BITS-1:0]    out_tag_o,
  output logic [htk_pkg::RANK_BITS-1:0]   rank_o,
  output logic                            last_o,
  output htk_pkg::status_t                status_o
);

  localparam int LB = htk_pkg::LEVEL_BITS;
  localparam int TB = htk_pkg::TAG_BITS;
  localparam int KB = htk_pkg::K_BITS;
  localparam int IB = htk_pkg::IDX_BITS;
  localparam int RB = htk_pkg::RANK_BITS;
  localparam int CB = htk_pkg::CNT_BITS;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_DIV    = 15'h0002,
    ST_APPEND = 15'h0004,
    ST_HSTEP  = 15'h0008,
    ST_REPL   = 15'h0010,
    ST_LOAD   = 15'h0020,
    ST_LDV    = 15'h0040,
    ST_READ   = 15'h0080,
    ST_CMP    = 15'h0100,
    ST_RPT    = 15'h0200,
    ST_FRPT   = 15'h0400,
    ST_POPRD  = 15'h0800,
    ST_POPOUT = 15'h1000,
    ST_POPLD  = 15'h2000,
    ST_POPV   = 15'h4000
  } state_e;

  typedef enum logic [4:0] {
    PH_FILL  = 5'b00001,
    PH_PRE   = 5'b00010,
    PH_REPL  = 5'b00100,
    PH_DRAIN = 5'b01000,
    PH_POP   = 5'b10000
  } phase_e;

  // heap store
  logic [LB-1:0] mem_lvl_q [htk_pkg::CAPACITY];
  logic [TB-1:0] mem_tag_q [htk_pkg::CAPACITY];
  logic [LB-1:0] rda_lvl_q, rdb_lvl_q;
  logic [TB-1:0] rda_tag_q, rdb_tag_q;
  logic [IB-1:0] ra, rb, wa;
  logic          we;
  logic [LB-1:0] wl;
  logic [TB-1:0] wt;

  state_e        state_q, state_d;
  phase_e        phase_q, phase_d;
  logic [KB-1:0] held_q, held_d;
  logic [CB-1:0] seen_q, seen_d;
  logic [KB-1:0] rem_q, rem_d;
  logic [LB-1:0] min_q, min_d;
  logic          heap_ok_q, heap_ok_d;
  logic          k_pend_q, k_pend_d;
  logic          rpt_q, rpt_d;
  logic [4:0]    div_cnt_q, div_cnt_d;
  logic [KB-1:0] div_r_q, div_r_d;
  logic [IB-1:0] pos_q, pos_d;
  logic [KB-1:0] size_q, size_d;
  logic [IB-1:0] hfy_q, hfy_d;
  logic [LB-1:0] v_lvl_q, v_lvl_d;
  logic [TB-1:0] v_tag_q, v_tag_d;
  logic [RB-1:0] rank_q, rank_d;

  logic          out_valid_q, out_valid_d;
  logic          o_kind_q, o_kind_d, o_last_q, o_last_d;
  logic [CB-1:0] o_seen_q, o_seen_d;
  logic [LB-1:0] o_lvl_q, o_lvl_d;
  logic [TB-1:0] o_tag_q, o_tag_d;
  logic [RB-1:0] o_rank_q, o_rank_d;

  logic [KB-1:0] k;
  logic          out_free;
  logic          comp;
  logic [KB-1:0] left;
  logic [KB:0]   right;
  logic          l_ok, r_ok, mv;
  logic [LB-1:0] best_l;
  logic [TB-1:0] best_t;
  logic [IB-1:0] tgt;
  logic [KB:0]   div_t;
  logic          adv;
  logic [KB-1:0] rem_n;

  assign k        = htk_pkg::eff_k(keep_k_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign comp     = (phase_q == PH_DRAIN) || (phase_q == PH_POP);

  // child selection of the sift-down step
  always_comb begin
    left   = {pos_q, 1'b1};
    right  = {1'b0, left} + (KB+1)'(1);
    l_ok   = left < size_q;
    r_ok   = right < {1'b0, size_q};
    mv     = 1'b0;
    best_l = v_lvl_q;
    best_t = v_tag_q;
    tgt    = pos_q;
    if (l_ok && htk_pkg::key_less(rda_lvl_q, rda_tag_q, best_l, best_t, comp)) begin
      mv     = 1'b1;
      best_l = rda_lvl_q;
      best_t = rda_tag_q;
      tgt    = left[IB-1:0];
    end
    if (r_ok && htk_pkg::key_less(rdb_lvl_q, rdb_tag_q, best_l, best_t, comp)) begin
      mv     = 1'b1;
      best_l = rdb_lvl_q;
      best_t = rdb_tag_q;
      tgt    = right[IB-1:0];
    end
  end

  // remainder restore step and count advance
  assign div_t = {div_r_q, seen_q[div_cnt_q]};
  assign adv   = (seen_q != '1);
  assign rem_n = !adv ? rem_q : ((rem_q + KB'(1) == k) ? '0 : rem_q + KB'(1));

  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    held_d      = held_q;
    seen_d      = seen_q;
    rem_d       = rem_q;
    min_d       = min_q;
    heap_ok_d   = heap_ok_q;
    k_pend_d    = k_pend_q || k_wr_i;
    rpt_d       = rpt_q;
    div_cnt_d   = div_cnt_q;
    div_r_d     = div_r_q;
    pos_d       = pos_q;
    size_d      = size_q;
    hfy_d       = hfy_q;
    v_lvl_d     = v_lvl_q;
    v_tag_d     = v_tag_q;
    rank_d      = rank_q;
    item_pop_o  = 1'b0;
    ra          = '0;
    rb          = '0;
    we          = 1'b0;
    wa          = '0;
    wl          = v_lvl_q;
    wt          = v_tag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_kind_d    = o_kind_q;
    o_last_d    = o_last_q;
    o_seen_d    = o_seen_q;
    o_lvl_d     = o_lvl_q;
    o_tag_d     = o_tag_q;
    o_rank_d    = o_rank_q;

    case (state_q)
      ST_IDLE: begin
        if (k_pend_q) begin
          k_pend_d  = k_wr_i;
          div_cnt_d = 5'd31;
          div_r_d   = '0;
          state_d   = ST_DIV;
        end else if (item_valid_i && (item_i.req_type == htk_pkg::REQ_ENTRY) &&
                     (held_q >= k) && !heap_ok_q) begin
          // rebuild the heap first; the entry waits at the head of the queue
          phase_d = PH_PRE;
          size_d  = held_q;
          hfy_d   = held_q[KB-1:1];
          state_d = ST_HSTEP;
        end else if (item_valid_i) begin
          item_pop_o = 1'b1;
          v_lvl_d    = item_i.level;
          v_tag_d    = item_i.tag;
          if (item_i.req_type == htk_pkg::REQ_ENTRY) begin
            seen_d = adv ? seen_q + CB'(1) : seen_q;
            rem_d  = rem_n;
            rpt_d  = adv && (rem_n == '0);
            if (held_q < k) begin
              state_d = ST_APPEND;
            end else begin
              state_d = ST_REPL;
            end
          end else if (held_q == '0) begin
            seen_d    = '0;
            rem_d     = '0;
            heap_ok_d = 1'b0;
          end else if ((seen_q == '0) || (rem_q != '0)) begin
            state_d = ST_FRPT;
          end else begin
            phase_d = PH_DRAIN;
            size_d  = held_q;
            hfy_d   = held_q[KB-1:1];
            rank_d  = '0;
            state_d = ST_HSTEP;
          end
        end
      end

      // seen % k, one bit per cycle
      ST_DIV: begin
        div_r_d   = (div_t >= {1'b0, k}) ? KB'(div_t - {1'b0, k}) : KB'(div_t);
        div_cnt_d = div_cnt_q - 5'd1;
        if (div_cnt_q == 5'd0) begin
          rem_d   = div_r_d;
          state_d = ST_IDLE;
        end
      end

      ST_APPEND: begin
        we        = 1'b1;
        wa        = held_q[IB-1:0];
        held_d    = held_q + KB'(1);
        heap_ok_d = 1'b0;
        min_d     = ((held_q == '0) || (v_lvl_q < min_q)) ? v_lvl_q : min_q;
        if (held_d == k) begin
          phase_d = PH_FILL;
          size_d  = held_d;
          hfy_d   = held_d[KB-1:1];
          state_d = ST_HSTEP;
        end else begin
          state_d = ST_RPT;
        end
      end

      // bottom-up heapify: one sift per interior node
      ST_HSTEP: begin
        if (hfy_q == '0) begin
          case (phase_q)
            PH_FILL: begin
              heap_ok_d = 1'b1;
              state_d   = ST_RPT;
            end
            PH_PRE: begin
              heap_ok_d = 1'b1;
              state_d   = ST_IDLE;
            end
            default: state_d = ST_POPRD;
          endcase
        end else begin
          pos_d   = hfy_q - IB'(1);
          hfy_d   = hfy_q - IB'(1);
          state_d = ST_LOAD;
        end
      end

      ST_REPL: begin
        if (v_lvl_q > min_q) begin
          phase_d = PH_REPL;
          pos_d   = '0;
          size_d  = held_q;
          state_d = ST_READ;
        end else begin
          state_d = ST_RPT;
        end
      end

      ST_LOAD: begin
        ra      = pos_q;
        state_d = ST_LDV;
      end

      ST_LDV: begin
        v_lvl_d = rda_lvl_q;
        v_tag_d = rda_tag_q;
        state_d = ST_READ;
      end

      ST_READ: begin
        ra      = left[IB-1:0];
        rb      = right[IB-1:0];
        state_d = ST_CMP;
      end

      // move the smaller child up, or drop the held entry into the hole
      ST_CMP: begin
        we = 1'b1;
        wa = pos_q;
        wl = best_l;
        wt = best_t;
        if (!comp && (pos_q == '0)) begin
          min_d = best_l;
        end
        if (mv) begin
          pos_d   = tgt;
          state_d = ST_READ;
        end else begin
          case (phase_q)
            PH_REPL: state_d = ST_RPT;
            PH_POP:  state_d = ST_POPRD;
            default: state_d = ST_HSTEP;
          endcase
        end
      end

      ST_RPT: begin
        if (!rpt_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = htk_pkg::KIND_REPORT;
          o_seen_d    = seen_q;
          o_lvl_d     = min_q;
          o_tag_d     = '0;
          o_rank_d    = '0;
          o_last_d    = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_FRPT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = htk_pkg::KIND_REPORT;
          o_seen_d    = seen_q;
          o_lvl_d     = min_q;
          o_tag_d     = '0;
          o_rank_d    = '0;
          o_last_d    = 1'b0;
          phase_d     = PH_DRAIN;
          size_d      = held_q;
          hfy_d       = held_q[KB-1:1];
          rank_d      = '0;
          state_d     = ST_HSTEP;
        end
      end

      ST_POPRD: begin
        ra      = '0;
        state_d = ST_POPOUT;
      end

      // emit the root, then refill it from the last slot
      ST_POPOUT: begin
        ra = '0;
        if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = htk_pkg::KIND_RANKED;
          o_seen_d    = seen_q;
          o_lvl_d     = rda_lvl_q;
          o_tag_d     = rda_tag_q;
          o_rank_d    = rank_q;
          o_last_d    = (KB'(rank_q) + KB'(1) == held_q);
          if (o_last_d) begin
            held_d    = '0;
            seen_d    = '0;
            rem_d     = '0;
            heap_ok_d = 1'b0;
            state_d   = ST_IDLE;
          end else begin
            rank_d  = rank_q + RB'(1);
            size_d  = held_q - KB'(rank_q) - KB'(1);
            state_d = ST_POPLD;
          end
        end
      end

      ST_POPLD: begin
        ra      = size_q[IB-1:0];
        state_d = ST_POPV;
      end

      ST_POPV: begin
        v_lvl_d = rda_lvl_q;
        v_tag_d = rda_tag_q;
        phase_d = PH_POP;
        pos_d   = '0;
        state_d = ST_READ;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FILL;
      held_q      <= '0;
      seen_q      <= '0;
      rem_q       <= '0;
      heap_ok_q   <= 1'b0;
      k_pend_q    <= 1'b0;
      rpt_q       <= 1'b0;
      div_cnt_q   <= '0;
      hfy_q       <= '0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      held_q      <= held_d;
      seen_q      <= seen_d;
      rem_q       <= rem_d;
      heap_ok_q   <= heap_ok_d;
      k_pend_q    <= k_pend_d;
      rpt_q       <= rpt_d;
      div_cnt_q   <= div_cnt_d;
      hfy_q       <= hfy_d;
      rank_q      <= rank_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    min_q    <= min_d;
    div_r_q  <= div_r_d;
    pos_q    <= pos_d;
    size_q   <= size_d;
    v_lvl_q  <= v_lvl_d;
    v_tag_q  <= v_tag_d;
    o_kind_q <= o_kind_d;
    o_last_q <= o_last_d;
    o_seen_q <= o_seen_d;
    o_lvl_q  <= o_lvl_d;
    o_tag_q  <= o_tag_d;
    o_rank_q <= o_rank_d;
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_lvl_q[wa] <= wl;
      mem_tag_q[wa] <= wt;
    end
    rda_lvl_q <= mem_lvl_q[ra];
    rda_tag_q <= mem_tag_q[ra];
    rdb_lvl_q <= mem_lvl_q[rb];
    rdb_tag_q <= mem_tag_q[rb];
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = o_kind_q;
  assign seen_count_o  = o_seen_q;
  assign out_level_o   = o_lvl_q;
  assign out_tag_o     = o_tag_q;
  assign rank_o        = o_rank_q;
  assign last_o        = o_last_q;
  assign status_o      = '{busy: (state_q != ST_IDLE), held: held_q};

endmodule

// ===== rtl/streaming_top_k_min_heap.sv =====
// ----------------------------------------------------------------------------
// streaming_top_k_min_heap
// Keeps the k highest-level entries of a stream and ranks them on finish.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): an entry (req_type 0) with level and
// tag, or a finish request (req_type 1). Items land in a two-entry queue, so
// the sender stalls only when the engine falls two items behind.
// Result channel (out_valid_o/out_ready_i): cutoff reports and ranked entries
// through a one-deep result register; last_o marks the final result of an item.
// APB port: keep_count at address 0; keep_count must be written only while the
// block is idle, and the block itself does not enforce it. Flow: the item that
// fills the store runs a heapify of k/2 sifts, and an entry meeting a store
// that is not yet a heap waits in the queue while a heapify of the held
// entries runs. A replacement takes one sift step per heap level. A finish
// runs a heapify, then one sift per heap level for each ranked entry. The heap
// store has a single write port and one sift unit. A keep_count write starts
// a remainder pass once the engine is idle. A stalled receiver holds the
// engine at its next result; the queue keeps taking items until full. Reset
// empties the store and queue, k returns to 32.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module streaming_top_k_min_heap (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [htk_pkg::LEVEL_BITS-1:0]  level_i,
  input  logic [htk_pkg::TAG_BITS-1:0]    entry_tag_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            result_kind_o,
  output logic [htk_pkg::CNT_BITS-1:0]    seen_count_o,
  output logic [htk_pkg::LEVEL_BITS-1:0]  out_level_o,
  output logic [htk_pkg::TAG_BITS-1:0]    out_tag_o,
  output logic [htk_pkg::RANK_BITS-1:0]   rank_o,
  output logic                            last_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [htk_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [htk_pkg::K_BITS-1:0] keep_q, keep_d;
  logic                       k_wr;
  logic                       item_valid, item_pop;
  htk_pkg::item_t             item;
  htk_pkg::status_t           st;

  // configuration register
  assign pready = 1'b1;
  assign k_wr   = psel && penable && pwrite && (paddr[2] == htk_pkg::REG_KEEP_COUNT);
  assign keep_d = k_wr ? pwdata[htk_pkg::K_BITS-1:0] : keep_q;
  assign prdata = (paddr[2] == htk_pkg::REG_KEEP_COUNT) ? 32'(keep_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= htk_pkg::KEEP_RESET;
    end else begin
      keep_q <= keep_d;
    end
  end

  htk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .level_i      (level_i),
    .entry_tag_i  (entry_tag_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  htk_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .keep_k_i      (keep_q),
    .k_wr_i        (k_wr),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .seen_count_o  (seen_count_o),
    .out_level_o   (out_level_o),
    .out_tag_o     (out_tag_o),
    .rank_o        (rank_o),
    .last_o        (last_o),
    .status_o      (st)
  );

  // checks
  `HTK_ASSERT_RST(a_rst_no_out, !rst_ni |-> !out_valid_o, "result valid during reset")
  `HTK_ASSERT(a_rank_in_store,
    out_valid_o && (result_kind_o == htk_pkg::KIND_RANKED) && !last_o |-> st.held > 6'(rank_o),
    "ranked entry beyond held count")
  `HTK_ASSERT(a_out_from_busy, $rose(out_valid_o) |-> $past(st.busy), "result from idle engine")

endmodule
